[hdl/i2crd_pkg.sv]
`timescale 1ns / 1ps

package i2crd_pkg;

    // Upper bound on the burst length; the capture index is six bits wide,
    // so the effective cap never exceeds 64.
    localparam int unsigned MAX_READ_LEN = 64;
    localparam int unsigned LEN_CAP_RAW  = (MAX_READ_LEN > 64) ? 64 : MAX_READ_LEN;
    localparam int unsigned LEN_CAP      = (LEN_CAP_RAW < 3) ? 3 : LEN_CAP_RAW;
    localparam logic [6:0]  LEN_MIN      = 7'd3;
    localparam logic [6:0]  LEN_MAX      = 7'(LEN_CAP);

    localparam logic [6:0]  TARGET_ADDRESS_RST   = 7'd39;
    localparam logic [7:0]  REGISTER_ADDRESS_RST = 8'd59;
    localparam logic [6:0]  READ_LENGTH_RST      = 7'd14;
    localparam logic [31:0] TIMEOUT_TICKS_RST    = 32'd50;

    typedef enum logic [1:0] {
        CFG_TARGET_ADDRESS   = 2'd0,
        CFG_REGISTER_ADDRESS = 2'd1,
        CFG_READ_LENGTH      = 2'd2,
        CFG_TIMEOUT_TICKS    = 2'd3
    } cfg_idx_t;

    typedef enum logic [0:0] {
        ACT_BEGIN = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_START      = 3'd1,
        CMD_ACK_RESTART = 3'd2,
        CMD_ACK_OFF    = 3'd3,
        CMD_STOP       = 3'd4,
        CMD_NACK_STOP  = 3'd5,
        CMD_STOP_RESET = 3'd6
    } bus_cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE          = 4'd0,
        PH_WAIT_START1   = 4'd1,
        PH_WAIT_ADDR1    = 4'd2,
        PH_WAIT_REG_TXE  = 4'd3,
        PH_WAIT_REG_BTF  = 4'd4,
        PH_WAIT_START2   = 4'd5,
        PH_WAIT_ADDR2    = 4'd6,
        PH_READ_MIDDLE   = 4'd7,
        PH_WAIT_BTF_PEN  = 4'd8,
        PH_WAIT_BTF_LAST = 4'd9
    } phase_t;

    typedef struct packed {
        logic [6:0]  target_address;
        logic [7:0]  register_address;
        logic [6:0]  read_length;
        logic [31:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [31:0] tick_now;
        logic        start_sent;
        logic        address_done;
        logic        nack_seen;
        logic        tx_empty;
        logic        transfer_finished;
        logic        rx_ready;
        logic [7:0]  rx_data;
    } item_t;

    typedef struct packed {
        logic [2:0] bus_command;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       capture_valid;
        logic [5:0] capture_index;
        logic [7:0] capture_byte;
        logic       done_res;
        logic       timed_out;
        logic [3:0] phase_code;
    } result_t;

endpackage

[hdl/i2crd_core.sv]
`timescale 1ns / 1ps

module i2crd_core
    import i2crd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    phase_t      phase_reg, phase_next;
    logic [31:0] start_tick_reg, start_tick_next;
    logic [5:0]  byte_count_reg, byte_count_next;

    logic [6:0]  len;
    logic [5:0]  len_m1;
    logic [5:0]  len_m2;
    logic [31:0] elapsed;
    logic        expired;
    logic [5:0]  count_inc;
    logic        middle_done;

    // Clamp the burst length on every poll; the register may change between reads.
    always_comb
    begin
        if (cfg.read_length < LEN_MIN)
            len = LEN_MIN;
        else if (cfg.read_length > LEN_MAX)
            len = LEN_MAX;
        else
            len = cfg.read_length;
    end

    assign len_m1      = 6'(len - 7'd1);
    assign len_m2      = 6'(len - 7'd2);
    assign elapsed     = item.tick_now - start_tick_reg;
    assign expired     = elapsed > cfg.timeout_ticks;
    assign count_inc   = byte_count_reg + 6'd1;
    assign middle_done = {1'b0, count_inc} >= (len - 7'd2);

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        start_tick_next = start_tick_reg;
        byte_count_next = byte_count_reg;
        if (item.action == ACT_BEGIN)
        begin
            phase_next      = PH_WAIT_START1;
            start_tick_next = item.tick_now;
            byte_count_next = 6'd0;
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (expired)
                phase_next = PH_IDLE;
            else
            begin
                case (phase_reg)
                    PH_WAIT_START1:
                        if (item.start_sent)
                            phase_next = PH_WAIT_ADDR1;
                    PH_WAIT_ADDR1:
                        if (item.address_done)
                            phase_next = PH_WAIT_REG_TXE;
                        else if (item.nack_seen)
                            phase_next = PH_IDLE;
                    PH_WAIT_REG_TXE:
                        if (item.tx_empty)
                            phase_next = PH_WAIT_REG_BTF;
                    PH_WAIT_REG_BTF:
                        if (item.transfer_finished)
                            phase_next = PH_WAIT_START2;
                    PH_WAIT_START2:
                        if (item.start_sent)
                            phase_next = PH_WAIT_ADDR2;
                    PH_WAIT_ADDR2:
                        if (item.address_done)
                        begin
                            byte_count_next = 6'd0;
                            phase_next      = PH_READ_MIDDLE;
                        end
                        else if (item.nack_seen)
                            phase_next = PH_IDLE;
                    PH_READ_MIDDLE:
                        if (item.rx_ready)
                        begin
                            byte_count_next = count_inc;
                            if (middle_done)
                                phase_next = PH_WAIT_BTF_PEN;
                        end
                    PH_WAIT_BTF_PEN:
                        if (item.transfer_finished)
                            phase_next = PH_WAIT_BTF_LAST;
                    PH_WAIT_BTF_LAST:
                        if (item.transfer_finished)
                            phase_next = PH_IDLE;
                    default:
                        phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Outputs
    always_comb
    begin
        result            = '0;
        result.phase_code = phase_reg;
        if (item.action == ACT_BEGIN)
            result.bus_command = CMD_START;
        else if (phase_reg != PH_IDLE)
        begin
            if (expired)
            begin
                result.bus_command = CMD_STOP_RESET;
                result.timed_out   = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_WAIT_START1:
                        if (item.start_sent)
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = {cfg.target_address, 1'b0};
                        end
                    PH_WAIT_ADDR1, PH_WAIT_ADDR2:
                        if (!item.address_done && item.nack_seen)
                            result.bus_command = CMD_NACK_STOP;
                    PH_WAIT_REG_TXE:
                        if (item.tx_empty)
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = cfg.register_address;
                        end
                    PH_WAIT_REG_BTF:
                        if (item.transfer_finished)
                            result.bus_command = CMD_ACK_RESTART;
                    PH_WAIT_START2:
                        if (item.start_sent)
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = {cfg.target_address, 1'b1};
                        end
                    PH_READ_MIDDLE:
                        if (item.rx_ready)
                        begin
                            result.capture_valid = 1'b1;
                            result.capture_index = byte_count_reg;
                            result.capture_byte  = item.rx_data;
                        end
                    PH_WAIT_BTF_PEN:
                        if (item.transfer_finished)
                        begin
                            result.bus_command   = CMD_ACK_OFF;
                            result.capture_valid = 1'b1;
                            result.capture_index = len_m2;
                            result.capture_byte  = item.rx_data;
                        end
                    PH_WAIT_BTF_LAST:
                        if (item.transfer_finished)
                        begin
                            result.bus_command   = CMD_STOP;
                            result.capture_valid = 1'b1;
                            result.capture_index = len_m1;
                            result.capture_byte  = item.rx_data;
                            result.done_res      = 1'b1;
                        end
                    default:
                        result.bus_command = CMD_NONE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            start_tick_reg <= '0;
            byte_count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            start_tick_reg <= start_tick_next;
            byte_count_reg <= byte_count_next;
        end
    end

endmodule

[hdl/i2c_register_read_sequencer.sv]
`timescale 1ns / 1ps

// I2C master register burst-read sequencer. Each poll item (begin or step,
// tick, bus status flags, received byte) produces exactly one result: a bus
// command plus optional transmit byte, captured byte with index, done or
// timeout flag, and the phase seen before the poll. One item is taken every
// clock while input stall is low. The phase logic sits between the input
// port and a two-entry output queue (output register plus skid register);
// a result goes to the skid register only while the output is held, so
// input stall rises only when both entries hold results the consumer has
// not taken. Configuration writes should be made while no result is pending.
module i2c_register_read_sequencer
    import i2crd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] tick_now,
    input  logic        start_sent,
    input  logic        address_done,
    input  logic        nack_seen,
    input  logic        tx_empty,
    input  logic        transfer_finished,
    input  logic        rx_ready,
    input  logic [7:0]  rx_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  bus_command,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        capture_valid,
    output logic [5:0]  capture_index,
    output logic [7:0]  capture_byte,
    output logic        done_res,
    output logic        timed_out,
    output logic [3:0]  phase_code
);

    cfg_t    cfg_reg;
    item_t   item;
    result_t step_result;
    logic    accept;
    logic    out_ready;

    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_address   <= TARGET_ADDRESS_RST;
            cfg_reg.register_address <= REGISTER_ADDRESS_RST;
            cfg_reg.read_length      <= READ_LENGTH_RST;
            cfg_reg.timeout_ticks    <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TARGET_ADDRESS:   cfg_reg.target_address   <= cfg_data[6:0];
                CFG_REGISTER_ADDRESS: cfg_reg.register_address <= cfg_data[7:0];
                CFG_READ_LENGTH:      cfg_reg.read_length      <= cfg_data[6:0];
                CFG_TIMEOUT_TICKS:    cfg_reg.timeout_ticks    <= cfg_data;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign item = '{
        action:            action,
        tick_now:          tick_now,
        start_sent:        start_sent,
        address_done:      address_done,
        nack_seen:         nack_seen,
        tx_empty:          tx_empty,
        transfer_finished: transfer_finished,
        rx_ready:          rx_ready,
        rx_data:           rx_data
    };

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_ready = !out_valid_reg || !out_stall;

    i2crd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    // Output register drains first; the skid entry catches a transfer that
    // arrives while the output is held.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_next       = step_result;
                out_valid_next = 1'b1;
            end
            else
                out_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_next       = step_result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign bus_command   = out_reg.bus_command;
    assign tx_valid      = out_reg.tx_valid;
    assign tx_byte       = out_reg.tx_byte;
    assign capture_valid = out_reg.capture_valid;
    assign capture_index = out_reg.capture_index;
    assign capture_byte  = out_reg.capture_byte;
    assign done_res      = out_reg.done_res;
    assign timed_out     = out_reg.timed_out;
    assign phase_code    = out_reg.phase_code;

endmodule

[hdl/i2crd_checker.sv]
`timescale 1ns / 1ps

module i2crd_checker
    import i2crd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  bus_command,
    input logic        tx_valid,
    input logic        capture_valid,
    input logic        done_res,
    input logic        timed_out,
    input logic [3:0]  phase_code
);

    // A held result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Input stall only rises after the output was held with a result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without a held result");

    // Completion comes only with the stop and the last captured byte.
    a_done_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> bus_command == CMD_STOP && capture_valid
            && phase_code == PH_WAIT_BTF_LAST && !timed_out)
        else $error("malformed completion result");

    // A timeout resets the bus and carries no byte in either direction.
    a_timeout_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> bus_command == CMD_STOP_RESET && !tx_valid
            && !capture_valid && phase_code != PH_IDLE)
        else $error("malformed timeout result");

endmodule

bind i2c_register_read_sequencer i2crd_checker u_i2crd_checker (.*);

[test/i2c_register_read_sequencer_tb.sv]
`timescale 1ns / 1ps

module i2c_register_read_sequencer_tb;
    import i2crd_pkg::*;

    localparam logic [5:0] F_SB   = 6'b100000;
    localparam logic [5:0] F_ADDR = 6'b010000;
    localparam logic [5:0] F_NACK = 6'b001000;
    localparam logic [5:0] F_TXE  = 6'b000100;
    localparam logic [5:0] F_BTF  = 6'b000010;
    localparam logic [5:0] F_RXNE = 6'b000001;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write = 1'b0;
    cfg_idx_t    cfg_index = CFG_TARGET_ADDRESS;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    item_t       poll_on_bus = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  bus_command;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        capture_valid;
    logic [5:0]  capture_index;
    logic [7:0]  capture_byte;
    logic        done_res;
    logic        timed_out;
    logic [3:0]  phase_code;

    // sequencer state and register copy used for prediction
    cfg_t        m_cfg = '{target_address: TARGET_ADDRESS_RST,
                           register_address: REGISTER_ADDRESS_RST,
                           read_length: READ_LENGTH_RST,
                           timeout_ticks: TIMEOUT_TICKS_RST};
    phase_t      m_phase = PH_IDLE;
    logic [31:0] m_start_tick = '0;
    logic [5:0]  m_byte_count = '0;

    item_t       pending_polls[$];
    result_t     expected_results[$];
    logic [31:0] gen_tick = '0;
    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count = 0;
    int unsigned hold_left = 0;
    int unsigned error_count = 0;

    i2c_register_read_sequencer uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (poll_on_bus.action),
        .tick_now          (poll_on_bus.tick_now),
        .start_sent        (poll_on_bus.start_sent),
        .address_done      (poll_on_bus.address_done),
        .nack_seen         (poll_on_bus.nack_seen),
        .tx_empty          (poll_on_bus.tx_empty),
        .transfer_finished (poll_on_bus.transfer_finished),
        .rx_ready          (poll_on_bus.rx_ready),
        .rx_data           (poll_on_bus.rx_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .bus_command       (bus_command),
        .tx_valid          (tx_valid),
        .tx_byte           (tx_byte),
        .capture_valid     (capture_valid),
        .capture_index     (capture_index),
        .capture_byte      (capture_byte),
        .done_res          (done_res),
        .timed_out         (timed_out),
        .phase_code        (phase_code)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [6:0] burst_len();
        if (m_cfg.read_length < LEN_MIN)
            return LEN_MIN;
        if (m_cfg.read_length > LEN_MAX)
            return LEN_MAX;
        return m_cfg.read_length;
    endfunction

    function automatic result_t predict_poll(item_t p);
        result_t     r;
        logic [6:0]  len;
        logic [31:0] elapsed;
        r = '0;
        r.phase_code = m_phase;
        len = burst_len();
        elapsed = p.tick_now - m_start_tick;
        if (p.action == ACT_BEGIN)
        begin
            m_phase = PH_WAIT_START1;
            m_start_tick = p.tick_now;
            m_byte_count = '0;
            r.bus_command = CMD_START;
        end
        else if (m_phase != PH_IDLE)
        begin
            if (elapsed > m_cfg.timeout_ticks)
            begin
                r.bus_command = CMD_STOP_RESET;
                r.timed_out = 1'b1;
                m_phase = PH_IDLE;
            end
            else
            begin
                case (m_phase)
                    PH_WAIT_START1:
                        if (p.start_sent)
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = {m_cfg.target_address, 1'b0};
                            m_phase = PH_WAIT_ADDR1;
                        end
                    PH_WAIT_ADDR1:
                        if (p.address_done)
                            m_phase = PH_WAIT_REG_TXE;
                        else if (p.nack_seen)
                        begin
                            r.bus_command = CMD_NACK_STOP;
                            m_phase = PH_IDLE;
                        end
                    PH_WAIT_REG_TXE:
                        if (p.tx_empty)
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = m_cfg.register_address;
                            m_phase = PH_WAIT_REG_BTF;
                        end
                    PH_WAIT_REG_BTF:
                        if (p.transfer_finished)
                        begin
                            r.bus_command = CMD_ACK_RESTART;
                            m_phase = PH_WAIT_START2;
                        end
                    PH_WAIT_START2:
                        if (p.start_sent)
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = {m_cfg.target_address, 1'b1};
                            m_phase = PH_WAIT_ADDR2;
                        end
                    PH_WAIT_ADDR2:
                        if (p.address_done)
                        begin
                            m_byte_count = '0;
                            m_phase = PH_READ_MIDDLE;
                        end
                        else if (p.nack_seen)
                        begin
                            r.bus_command = CMD_NACK_STOP;
                            m_phase = PH_IDLE;
                        end
                    PH_READ_MIDDLE:
                        if (p.rx_ready)
                        begin
                            r.capture_valid = 1'b1;
                            r.capture_index = m_byte_count;
                            r.capture_byte = p.rx_data;
                            m_byte_count = m_byte_count + 6'd1;
                            // a lowered length ends the middle part at once
                            if (7'(m_byte_count) >= len - 7'd2)
                                m_phase = PH_WAIT_BTF_PEN;
                        end
                    PH_WAIT_BTF_PEN:
                        if (p.transfer_finished)
                        begin
                            r.bus_command = CMD_ACK_OFF;
                            r.capture_valid = 1'b1;
                            r.capture_index = 6'(len - 7'd2);
                            r.capture_byte = p.rx_data;
                            m_phase = PH_WAIT_BTF_LAST;
                        end
                    PH_WAIT_BTF_LAST:
                        if (p.transfer_finished)
                        begin
                            r.bus_command = CMD_STOP;
                            r.capture_valid = 1'b1;
                            r.capture_index = 6'(len - 7'd1);
                            r.capture_byte = p.rx_data;
                            r.done_res = 1'b1;
                            m_phase = PH_IDLE;
                        end
                    default:
                        m_phase = PH_IDLE;
                endcase
            end
        end
        return r;
    endfunction

    // flag that moves the read on from a given phase
    function automatic logic [5:0] stage_flag(int k);
        case (phase_t'(k))
            PH_WAIT_START1, PH_WAIT_START2:  return F_SB;
            PH_WAIT_ADDR1, PH_WAIT_ADDR2:    return F_ADDR;
            PH_WAIT_REG_TXE:                 return F_TXE;
            PH_READ_MIDDLE:                  return F_RXNE;
            default:                         return F_BTF;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic push_poll(action_t act, logic [5:0] flags, logic [7:0] rx);
        item_t p;
        p.action = act;
        p.tick_now = gen_tick;
        {p.start_sent, p.address_done, p.nack_seen, p.tx_empty,
         p.transfer_finished, p.rx_ready} = flags;
        p.rx_data = rx;
        pending_polls.push_back(p);
        queued_count++;
    endtask

    task automatic advance_tick();
        if ($urandom_range(3) == 0)
            gen_tick = gen_tick + 32'd1;
    endtask

    task automatic wait_all_done();
        do
            @(negedge clk);
        while (pending_polls.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_TARGET_ADDRESS:   m_cfg.target_address = value[6:0];
            CFG_REGISTER_ADDRESS: m_cfg.register_address = value[7:0];
            CFG_READ_LENGTH:      m_cfg.read_length = value[6:0];
            default:              m_cfg.timeout_ticks = value;
        endcase
    endtask

    task automatic set_config(logic [31:0] target, logic [31:0] regaddr,
                              logic [31:0] len, logic [31:0] limit);
        write_reg(CFG_TARGET_ADDRESS, target);
        write_reg(CFG_REGISTER_ADDRESS, regaddr);
        write_reg(CFG_READ_LENGTH, len);
        write_reg(CFG_TIMEOUT_TICKS, limit);
    endtask

    // one read with random waits and the odd nack, timeout or early restart
    task automatic queue_read();
        int unsigned reps;
        int unsigned roll;
        logic [5:0]  key;
        logic [5:0]  wait_mask;
        logic [31:0] began;
        began = gen_tick;
        push_poll(ACT_BEGIN, 6'($urandom), 8'($urandom));
        for (int k = PH_WAIT_START1; k <= PH_WAIT_BTF_LAST; k++)
        begin
            key = stage_flag(k);
            wait_mask = (key == F_ADDR) ? ~(key | F_NACK) : ~key;
            reps = (k == PH_READ_MIDDLE) ? burst_len() - 2 : 1;
            for (int r = 0; r < reps; r++)
            begin
                repeat ($urandom_range(2))
                begin
                    advance_tick();
                    push_poll(ACT_STEP, 6'($urandom) & wait_mask, 8'($urandom));
                end
                roll = $urandom_range(99);
                advance_tick();
                if (roll < 5 && key == F_ADDR)
                begin
                    push_poll(ACT_STEP, (6'($urandom) & ~F_ADDR) | F_NACK, 8'($urandom));
                    return;
                end
                if (roll == 99 && m_cfg.timeout_ticks < 32'hFFFF_FF00)
                begin
                    gen_tick = began + m_cfg.timeout_ticks + 32'd1 + $urandom_range(3);
                    push_poll(ACT_STEP, 6'($urandom), 8'($urandom));
                    return;
                end
                // drop the read; the next begin restarts it
                if (roll == 98)
                    return;
                push_poll(ACT_STEP, 6'($urandom) | key, 8'($urandom));
            end
        end
    endtask

    task automatic run_random(int unsigned count);
        int unsigned stop_at;
        stop_at = queued_count + count;
        gen_tick = $urandom;
        while (queued_count < stop_at)
        begin
            repeat ($urandom_range(1))
            begin
                advance_tick();
                push_poll(ACT_STEP, 6'($urandom), 8'($urandom));
            end
            queue_read();
        end
        wait_all_done();
    endtask

    // sender: offer pending polls, hold while stalled
    always @(posedge clk)
    begin : poll_driver
        bit quiet;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            quiet = accepted_count inside {[400:549]};
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_poll(poll_on_bus));
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_polls.size() != 0 && (quiet || $urandom_range(99) >= 11))
                begin
                    poll_on_bus <= pending_polls.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each transfer against the oldest expected result
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: bus_command %0d phase_code %0d",
                           bus_command, phase_code);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("bus_command", want.bus_command, bus_command);
                    check_field("tx_valid", want.tx_valid, tx_valid);
                    check_field("tx_byte", want.tx_byte, tx_byte);
                    check_field("capture_valid", want.capture_valid, capture_valid);
                    check_field("capture_index", want.capture_index, capture_index);
                    check_field("capture_byte", want.capture_byte, capture_byte);
                    check_field("done_res", want.done_res, done_res);
                    check_field("timed_out", want.timed_out, timed_out);
                    check_field("phase_code", want.phase_code, phase_code);
                end
                checked_count++;
                // long hold-off so the block backs up into its input
                if (checked_count % 500 == 200)
                    hold_left = 60;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= !(checked_count inside {[400:549]}) && ($urandom_range(99) < 11);
            end
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(CFG_READ_LENGTH, 32'd3);
        @(negedge clk);

        // idle poll with every flag up
        gen_tick = '1;
        push_poll(ACT_STEP, 6'h3F, 8'hFF);
        // shortest burst across the tick wrap, finishing right at the limit
        gen_tick = 32'hFFFF_FFFE;
        push_poll(ACT_BEGIN, 6'h00, 8'h00);
        push_poll(ACT_STEP, 6'h00, 8'h00);
        gen_tick = 32'hFFFF_FFFF;
        push_poll(ACT_STEP, F_SB, 8'h00);
        gen_tick = 32'd0;
        push_poll(ACT_STEP, F_ADDR | F_NACK, 8'h00);
        push_poll(ACT_STEP, F_TXE, 8'h00);
        push_poll(ACT_STEP, F_BTF, 8'h00);
        push_poll(ACT_STEP, F_SB, 8'h00);
        push_poll(ACT_STEP, F_ADDR, 8'h00);
        push_poll(ACT_STEP, F_RXNE, 8'hA5);
        push_poll(ACT_STEP, F_BTF, 8'h00);
        gen_tick = 32'd48;
        push_poll(ACT_STEP, F_BTF | F_RXNE, 8'hFF);
        // nack on the write address
        gen_tick = 32'd100;
        push_poll(ACT_BEGIN, 6'h00, 8'h00);
        push_poll(ACT_STEP, F_SB, 8'h00);
        push_poll(ACT_STEP, F_NACK, 8'h00);
        // one tick past the limit
        gen_tick = 32'd200;
        push_poll(ACT_BEGIN, 6'h00, 8'h00);
        gen_tick = 32'd251;
        push_poll(ACT_STEP, F_SB, 8'h00);
        // nack on the read address
        gen_tick = 32'd300;
        push_poll(ACT_BEGIN, 6'h00, 8'h00);
        push_poll(ACT_STEP, F_SB, 8'h00);
        push_poll(ACT_STEP, F_ADDR, 8'h00);
        push_poll(ACT_STEP, F_TXE, 8'h00);
        push_poll(ACT_STEP, F_BTF, 8'h00);
        push_poll(ACT_STEP, F_SB, 8'h00);
        push_poll(ACT_STEP, F_NACK | F_TXE | F_BTF | F_RXNE, 8'h00);
        // begin while a read is in flight
        gen_tick = 32'd400;
        push_poll(ACT_BEGIN, 6'h00, 8'h00);
        push_poll(ACT_STEP, F_SB, 8'h00);
        gen_tick = 32'd401;
        push_poll(ACT_BEGIN, 6'h3F, 8'h5A);
        wait_all_done();

        // lower the length in the middle of a burst
        write_reg(CFG_READ_LENGTH, 32'd10);
        @(negedge clk);
        gen_tick = 32'd1000;
        push_poll(ACT_BEGIN, 6'h00, 8'h00);
        push_poll(ACT_STEP, F_SB, 8'h00);
        push_poll(ACT_STEP, F_ADDR, 8'h00);
        push_poll(ACT_STEP, F_TXE, 8'h00);
        push_poll(ACT_STEP, F_BTF, 8'h00);
        push_poll(ACT_STEP, F_SB, 8'h00);
        push_poll(ACT_STEP, F_ADDR, 8'h00);
        repeat (5) push_poll(ACT_STEP, F_RXNE, 8'($urandom));
        wait_all_done();
        write_reg(CFG_READ_LENGTH, 32'd4);
        @(negedge clk);
        push_poll(ACT_STEP, F_RXNE, 8'h11);
        push_poll(ACT_STEP, F_BTF, 8'h22);
        push_poll(ACT_STEP, F_BTF, 8'h33);
        wait_all_done();

        set_config(TARGET_ADDRESS_RST, REGISTER_ADDRESS_RST, READ_LENGTH_RST,
                   TIMEOUT_TICKS_RST);
        run_random(150);
        set_config({25'($urandom), 7'h7F}, 32'd255, 32'd64, 32'hFFFF_FFFF);
        run_random(150);
        set_config(32'd0, 32'd0, 32'd3, 32'd0);
        run_random(150);
        set_config($urandom, $urandom, 32'd0, 32'd1);
        run_random(150);
        set_config($urandom, $urandom, 32'd127, $urandom);
        run_random(150);
        set_config($urandom, $urandom, 32'd2, 32'd20);
        run_random(150);
        set_config($urandom, $urandom, $urandom_range(64, 3), $urandom_range(200, 5));
        run_random(150);

        repeat (20) @(negedge clk);
        if (error_count == 0)
            $display("i2c_register_read_sequencer_tb: clean");
        else
            $display("i2c_register_read_sequencer_tb: errors");
        $finish;
    end

    initial
    begin : watchdog
        #200000;
        $display("i2c_register_read_sequencer_tb: errors");
        $finish;
    end

endmodule

[files.f]
hdl/i2crd_pkg.sv
hdl/i2crd_core.sv
hdl/i2c_register_read_sequencer.sv
hdl/i2crd_checker.sv
test/i2c_register_read_sequencer_tb.sv
